### hw/rtl/lzwc_pkg.sv
// ----------------------------------------------------------------------------
// lzwc_pkg: shared types and constants of the LZW byte compressor
// Code widths, dictionary geometry, controller states, command and status.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int BYTE_W       = 8;
    localparam int CODE_W       = 9;
    localparam int COUNT_W      = CODE_W + 1;
    localparam int ENTRY_W      = CODE_W + BYTE_W;
    localparam int CODE_SPACE   = 1 << CODE_W;
    localparam int FIRST_ENTRY  = 1 << BYTE_W;
    localparam int STORE_DEPTH  = CODE_SPACE - FIRST_ENTRY;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int DICT_ENTRIES = 512;
    localparam int ENTRY_LIMIT  = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;
    localparam logic [CODE_W-1:0] EMPTY_HIGHEST = CODE_W'(FIRST_ENTRY - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIRST = 5'b00010,
        S_SCAN  = 5'b00100,
        S_MISS  = 5'b01000,
        S_LAST  = 5'b10000
    } ctrl_state_t;

    typedef struct packed {
        logic accept;     // take a byte request, start a scan at highest entry
        logic scan_step;  // issue one dictionary read while entries remain, move down one entry
        logic take_hit;   // prefix becomes the matched entry
        logic take_miss;  // emit prefix, add entry while there is room, restart from the byte
        logic emit_last;  // emit final prefix, return to reset values
    } ctrl_cmd_t;

    typedef struct packed {
        logic prefix_valid;
        logic eos;
        logic scan_more;
        logic cmp_valid;
        logic cmp_hit;
        logic out_free;
    } dp_status_t;

endpackage

### hw/rtl/lzwc_if.sv
// ----------------------------------------------------------------------------
// lzwc_if: request channels of the LZW byte compressor
// Byte channel in, code channel out, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lzwc_byte_if;
    logic                         valid;
    logic                         ready;
    logic [lzwc_pkg::BYTE_W-1:0]  data_byte;
    logic                         end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lzwc_code_if;
    logic                         valid;
    logic                         ready;
    logic [lzwc_pkg::CODE_W-1:0]  code;
    logic                         last_code;

    modport source (output valid, output code, output last_code, input ready);
    modport sink   (input valid, input code, input last_code, output ready);
endinterface

### hw/rtl/lzwc_ram.sv
// ----------------------------------------------------------------------------
// lzwc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lzwc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lzwc_datapath.sv
// ----------------------------------------------------------------------------
// lzwc_datapath: prefix, dictionary scan and output register
// Holds the current prefix, scans the dictionary RAM one entry a cycle,
// and keeps the result register toward the code channel.
// ----------------------------------------------------------------------------
module lzwc_datapath #(
    parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lzwc_pkg::ctrl_cmd_t         cmd,
    output lzwc_pkg::dp_status_t        status,
    input  logic [lzwc_pkg::BYTE_W-1:0] in_data,
    input  logic                        in_eos,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lzwc_pkg::CODE_W-1:0] out_code,
    output logic                        out_last
);
    import lzwc_pkg::*;

    // Codes stay CODE_W bits wide, so the dictionary stops at the code space.
    localparam int ADD_LIMIT = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;

    logic [BYTE_W-1:0]  byte_reg;
    logic               eos_reg;
    logic [CODE_W-1:0]  prefix_reg;
    logic               prefix_valid_reg;
    logic [CODE_W-1:0]  highest_reg;
    logic [CODE_W-1:0]  scan_reg;
    logic [CODE_W-1:0]  cmp_code_reg;
    logic               cmp_valid_reg;
    logic               out_valid_reg;
    logic [CODE_W-1:0]  out_code_reg;
    logic               out_last_reg;

    logic [COUNT_W-1:0] highest_inc;
    logic               room;
    logic               ram_we;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] want;

    assign want        = {prefix_reg, byte_reg};
    assign highest_inc = {1'b0, highest_reg} + COUNT_W'(1);
    assign room        = highest_inc < COUNT_W'(ADD_LIMIT);
    assign ram_we      = cmd.take_miss && room;
    assign ram_re      = cmd.scan_step && scan_reg[CODE_W-1];

    lzwc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (highest_inc[STORE_AW-1:0]),
        .wdata (want),
        .re    (ram_re),
        .raddr (scan_reg[STORE_AW-1:0]),
        .rdata (ram_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_valid_reg <= 1'b0;
            highest_reg      <= EMPTY_HIGHEST;
            cmp_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= ram_re;
            if (cmd.accept)
            begin
                prefix_valid_reg <= 1'b1;
            end
            if (ram_we)
            begin
                highest_reg <= highest_inc[CODE_W-1:0];
            end
            if (cmd.emit_last)
            begin
                prefix_valid_reg <= 1'b0;
                highest_reg      <= EMPTY_HIGHEST;
            end
            if (cmd.take_miss || cmd.emit_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg <= in_data;
            eos_reg  <= in_eos;
            scan_reg <= highest_reg;
            if (!prefix_valid_reg)
            begin
                prefix_reg <= CODE_W'(in_data);
            end
        end
        if (cmd.scan_step)
        begin
            scan_reg     <= scan_reg - CODE_W'(1);
            cmp_code_reg <= scan_reg;
        end
        if (cmd.take_hit)
        begin
            prefix_reg <= cmp_code_reg;
        end
        if (cmd.take_miss)
        begin
            out_code_reg <= prefix_reg;
            out_last_reg <= 1'b0;
            prefix_reg   <= CODE_W'(byte_reg);
        end
        if (cmd.emit_last)
        begin
            out_code_reg <= prefix_reg;
            out_last_reg <= 1'b1;
            prefix_reg   <= '0;
        end
    end

    assign status.prefix_valid = prefix_valid_reg;
    assign status.eos          = eos_reg;
    assign status.scan_more    = scan_reg[CODE_W-1];
    assign status.cmp_valid    = cmp_valid_reg;
    assign status.cmp_hit      = cmp_valid_reg && (ram_rdata == want);
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_last  = out_last_reg;

endmodule

### hw/rtl/lzwc_ctrl.sv
// ----------------------------------------------------------------------------
// lzwc_ctrl: sequencing state machine of the LZW byte compressor
// Accepts a byte, runs the dictionary scan, then issues emit commands.
// ----------------------------------------------------------------------------
module lzwc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lzwc_pkg::dp_status_t status,
    output lzwc_pkg::ctrl_cmd_t  cmd
);
    import lzwc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.prefix_valid ? S_SCAN : S_FIRST;
                end
            end
            S_FIRST:
            begin
                state_next = status.eos ? S_LAST : S_IDLE;
            end
            S_SCAN:
            begin
                // Hit wins over a further scan step and over the end of the scan.
                priority if (status.cmp_hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = status.eos ? S_LAST : S_IDLE;
                end
                else if (!status.cmp_valid && !status.scan_more)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_MISS:
            begin
                if (status.out_free)
                begin
                    cmd.take_miss = 1'b1;
                    state_next    = status.eos ? S_LAST : S_IDLE;
                end
            end
            S_LAST:
            begin
                if (status.out_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/lzw_byte_compressor.sv
// ----------------------------------------------------------------------------
// lzw_byte_compressor: LZW compressor with fixed 9-bit codes
// Top level joining the controller, the datapath and the dictionary RAM.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one raw byte per request, with end_of_stream set on the
//   last byte of a stream. code_out carries 9-bit codes (0-255 literal,
//   256-511 dictionary entry); last_code marks the final code of a stream.
//   Each byte yields zero, one or two codes.
// Timing:
//   A byte is taken only while the controller is idle. The first byte of a
//   stream only passes through S_FIRST. Every later byte scans the dictionary
//   from the highest entry down, one RAM read per cycle with registered read
//   data: a hit ends the scan, and a miss, once all N entries are read, goes
//   to S_MISS to emit the prefix, N being the number of entries (up to 256).
//   The end of a stream passes through S_LAST for the final code. The single
//   read port sets the rate: a new byte waits until the last is through.
// Reset:
//   Reset, like each end of stream, clears the prefix and empties the
//   dictionary; RAM contents are never read before written, so no clearing.
// Stall:
//   Codes wait in a single output register. A new byte is still accepted
//   while a code waits; the block holds only when it must emit a code and the
//   register is still full.
// ----------------------------------------------------------------------------
module lzw_byte_compressor #(
    parameter int DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    lzwc_byte_if.sink   byte_in,
    lzwc_code_if.source code_out
);
    import lzwc_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequence each byte request through scan and emit.
    lzwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_in.valid),
        .in_ready (byte_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold prefix, dictionary and the output register.
    lzwc_datapath #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (byte_in.data_byte),
        .in_eos    (byte_in.end_of_stream),
        .out_valid (code_out.valid),
        .out_ready (code_out.ready),
        .out_code  (code_out.code),
        .out_last  (code_out.last_code)
    );

endmodule
